// File: rtl/pirm_pkg.sv
// Package for the positional insert range minimum block: sizes, codes and shared types.
package pirm_pkg;

	localparam int CAPACITY = 1024;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 11;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic signed [VALUE_W-1:0] EMPTY_SENTINEL = VALUE_W'(1000000000);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} state_t;

	// Broadcast to every cell when an insert is taken.
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   pos;
		logic [VALUE_W-1:0] value;
	} ins_t;

	// Inclusive 0-based bounds of the range being scanned.
	typedef struct packed {
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
	} qry_t;

	// Running minimum that travels down the chain, one cell per cycle.
	typedef struct packed {
		logic               valid;
		logic               have;
		logic [VALUE_W-1:0] acc;
	} tok_t;

endpackage

// File: rtl/pirm_in_if.sv
// Input channel: command beats carrying insert and query requests.
interface pirm_in_if;
	import pirm_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [POS_W-1:0]           position;
	logic signed [VALUE_W-1:0]  value;
	logic [POS_W-1:0]           range_first;
	logic [POS_W-1:0]           range_last;

	modport source (
		output valid, command, position, value, range_first, range_last,
		input  ready
	);

	modport sink (
		input  valid, command, position, value, range_first, range_last,
		output ready
	);

endinterface

// File: rtl/pirm_out_if.sv
// Output channel: one result beat per request.
interface pirm_out_if;
	import pirm_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  minimum;
	logic                       status;

	modport source (
		output valid, minimum, status,
		input  ready
	);

	modport sink (
		input  valid, minimum, status,
		output ready
	);

endinterface

// File: rtl/pirm_cell.sv
// One storage cell of the chain: holds a value, shifts on insert, folds the passing minimum.
module pirm_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pirm_pkg::IDX_W-1:0]    cell_index,
	input  pirm_pkg::ins_t                ins,
	input  pirm_pkg::qry_t                qry,
	input  logic [pirm_pkg::VALUE_W-1:0]  prev_value,
	input  pirm_pkg::tok_t                tok_in,
	output logic [pirm_pkg::VALUE_W-1:0]  cell_value,
	output pirm_pkg::tok_t                tok_out
);
	import pirm_pkg::*;

	logic [VALUE_W-1:0] val_q;
	tok_t               tok_q;
	tok_t               tok_d;
	logic               in_range;

	assign in_range = (cell_index >= qry.lo) && (cell_index <= qry.hi);

	always_comb begin
		tok_d = tok_in;
		if (tok_in.valid && in_range &&
		    (!tok_in.have || ($signed(val_q) < $signed(tok_in.acc)))) begin
			tok_d.have = 1'b1;
			tok_d.acc  = val_q;
		end
	end

	// Cells past the insert point take their left neighbor's value.
	always_ff @(posedge clk) begin
		if (ins.en) begin
			if (cell_index == ins.pos) begin
				val_q <= ins.value;
			end else if (cell_index > ins.pos) begin
				val_q <= prev_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign cell_value = val_q;
	assign tok_out    = tok_q;

endmodule

// File: rtl/pirm_ctrl.sv
// Controller: takes requests, keeps the entry count, launches scans and holds the result beat.
module pirm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	pirm_in_if.sink          request,
	pirm_out_if.source       response,
	input  pirm_pkg::tok_t   tail,
	output pirm_pkg::ins_t   ins,
	output pirm_pkg::qry_t   qry,
	output pirm_pkg::tok_t   head
);
	import pirm_pkg::*;

	state_t                state_q;
	state_t                state_d;
	logic [CNT_W-1:0]      count_q;
	qry_t                  qry_q;
	tok_t                  inject_q;
	logic [VALUE_W-1:0]    res_min_q;
	logic                  res_status_q;
	logic                  out_valid_q;
	logic [VALUE_W-1:0]    out_min_q;
	logic                  out_status_q;

	logic                  accept;
	logic                  ins_cmd;
	logic                  full;
	logic                  load_out;
	logic [CMP_W-1:0]      count_w;
	logic [CMP_W-1:0]      pos_w;
	logic [CMP_W-1:0]      pos_eff;
	logic [CMP_W-1:0]      first_eff;
	logic [CMP_W-1:0]      last_w;
	logic [CMP_W-1:0]      last_eff;
	logic                  empty;

	assign count_w   = CMP_W'(count_q);
	assign pos_w     = CMP_W'(request.position);
	assign pos_eff   = (pos_w > count_w) ? count_w : pos_w;
	assign first_eff = (request.range_first == '0) ? CMP_W'(1) : CMP_W'(request.range_first);
	assign last_w    = CMP_W'(request.range_last);
	assign last_eff  = (last_w > count_w) ? count_w : last_w;
	assign empty     = first_eff > last_eff;
	assign full      = count_q == CNT_W'(CAPACITY);
	assign ins_cmd   = request.command == CMD_INSERT;
	assign accept    = request.valid && request.ready;

	// Outputs of the state machine.
	always_comb begin
		request.ready = state_q == ST_IDLE;
		load_out      = (state_q == ST_RESULT) && (!out_valid_q || response.ready);
		ins.en        = accept && ins_cmd && !full;
		ins.pos       = IDX_W'(pos_eff);
		ins.value     = request.value;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (ins_cmd || empty) begin
						state_d = ST_RESULT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (tail.valid) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			inject_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			inject_q.valid <= accept && !ins_cmd && !empty;
			inject_q.have  <= 1'b0;
			inject_q.acc   <= '0;
			if (ins.en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (ins_cmd) begin
				res_min_q    <= '0;
				res_status_q <= full ? STATUS_FULL : STATUS_DONE;
			end else begin
				res_min_q    <= EMPTY_SENTINEL;
				res_status_q <= STATUS_DONE;
				qry_q.lo     <= IDX_W'(first_eff - CMP_W'(1));
				qry_q.hi     <= IDX_W'(last_eff - CMP_W'(1));
			end
		end
		if ((state_q == ST_SCAN) && tail.valid) begin
			res_min_q <= tail.acc;
		end
		if (load_out) begin
			out_min_q    <= res_min_q;
			out_status_q <= res_status_q;
		end
	end

	assign qry              = qry_q;
	assign head             = inject_q;
	assign response.valid   = out_valid_q;
	assign response.minimum = out_min_q;
	assign response.status  = out_status_q;

endmodule

// File: rtl/positional_insert_range_min.sv
// Top level: ordered value store as a chain of cells with positional insert and range minimum.
//
//   channel    dir  payload                                              beat
//   request    in   command, position, value, range_first, range_last    one per item
//   response   out  minimum, status                                      one per item
//
// An insert shifts the chain at the edge that takes its beat; its result is then loaded into the
// output register once that register is free. A query sends a running minimum down the
// chain, one cell per cycle, and its result is loaded into the output register once the scan
// ends and the register is free; an empty range skips the scan.
// One item is in work at a time; a new request is taken while the previous result still
// waits in the output register. Reset clears the entry count and the control state.
module positional_insert_range_min (
	input  logic        clk,
	input  logic        arst_n,
	pirm_in_if.sink     request,
	pirm_out_if.source  response
);
	import pirm_pkg::*;

	ins_t               ins;
	qry_t               qry;
	tok_t               head;
	tok_t               tok   [CAPACITY];
	logic [VALUE_W-1:0] cells [CAPACITY];

	pirm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.response (response),
		.tail     (tok[CAPACITY-1]),
		.ins      (ins),
		.qry      (qry),
		.head     (head)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			pirm_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cell_index (IDX_W'(i)),
				.ins        (ins),
				.qry        (qry),
				.prev_value (ins.value),
				.tok_in     (head),
				.cell_value (cells[i]),
				.tok_out    (tok[i])
			);
		end else begin : g_rest
			pirm_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cell_index (IDX_W'(i)),
				.ins        (ins),
				.qry        (qry),
				.prev_value (cells[i-1]),
				.tok_in     (tok[i-1]),
				.cell_value (cells[i]),
				.tok_out    (tok[i])
			);
		end
	end

endmodule

// File: tb/positional_insert_range_min_test.sv
// Testbench for positional_insert_range_min: directed, random, back-pressure and full-store traffic.
`timescale 1ns / 100ps

module positional_insert_range_min_test;
	import pirm_pkg::*;

	localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam int POS_MAX = (1 << POS_W) - 1;

	typedef struct {
		logic signed [VALUE_W-1:0] minimum;
		logic                      status;
	} response_t;

	logic clk;
	logic arst_n;

	pirm_in_if  req_ch();
	pirm_out_if rsp_ch();

	positional_insert_range_min dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (req_ch),
		.response (rsp_ch)
	);

	// Our own copy of the stored sequence, in order.
	logic signed [VALUE_W-1:0] seq_cells[$];
	response_t awaited_responses[$];

	int error_count     = 0;
	int send_idle_pct   = 0;
	int recv_idle_pct   = 0;
	int hold_off_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("positional_insert_range_min_test failed");
		$finish;
	end

	function automatic response_t compute_response(input logic cmd,
			input logic [POS_W-1:0] pos, input logic signed [VALUE_W-1:0] val,
			input logic [POS_W-1:0] first, input logic [POS_W-1:0] last);
		response_t   r;
		int unsigned lo;
		int unsigned hi;
		int unsigned at;
		r.minimum = '0;
		r.status  = STATUS_DONE;
		if (cmd == CMD_INSERT) begin
			if (seq_cells.size() >= CAPACITY) begin
				r.status = STATUS_FULL;
			end else begin
				at = (pos > seq_cells.size()) ? seq_cells.size() : pos;
				seq_cells.insert(at, val);
			end
		end else begin
			lo = (first == 0) ? 1 : first;
			hi = (last > seq_cells.size()) ? seq_cells.size() : last;
			r.minimum = EMPTY_SENTINEL;
			if (lo <= hi) begin
				r.minimum = seq_cells[lo-1];
				for (int i = lo; i < hi; i++) begin
					if (seq_cells[i] < r.minimum)
						r.minimum = seq_cells[i];
				end
			end
		end
		return r;
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(9))
			0: pick_value = VALUE_MIN;
			1: pick_value = VALUE_MAX;
			2: pick_value = EMPTY_SENTINEL;
			3: pick_value = EMPTY_SENTINEL + 1;
			4: pick_value = EMPTY_SENTINEL - 1;
			5, 6: pick_value = $signed($urandom_range(16)) - 8;
			default: pick_value = $urandom;
		endcase
	endfunction

	// Valid stays high between back-to-back beats; it only drops for a gap or in release_request.
	task automatic send_request(input logic cmd, input logic [POS_W-1:0] pos,
			input logic signed [VALUE_W-1:0] val, input logic [POS_W-1:0] first,
			input logic [POS_W-1:0] last);
		int        gap;
		response_t predicted;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.command     <= cmd;
		req_ch.position    <= pos;
		req_ch.value       <= val;
		req_ch.range_first <= first;
		req_ch.range_last  <= last;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = compute_response(cmd, pos, val, first, last);
		awaited_responses.insert(awaited_responses.size(), predicted);
	endtask

	task automatic release_request();
		req_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_insert(input int pos, input logic signed [VALUE_W-1:0] val);
		send_request(CMD_INSERT, POS_W'(pos), val, POS_W'($urandom), POS_W'($urandom));
	endtask

	task automatic send_query(input int first, input int last);
		send_request(CMD_QUERY, POS_W'($urandom), $urandom, POS_W'(first), POS_W'(last));
	endtask

	task automatic send_random_item(input int insert_pct);
		int unsigned n;
		int unsigned f;
		int unsigned l;
		n = seq_cells.size();
		if ($urandom_range(99) < insert_pct) begin
			case ($urandom_range(19))
				0, 1, 2: send_insert($urandom_range(0, POS_MAX), pick_value());
				3, 4:    send_insert(n, pick_value());
				default: send_insert($urandom_range(0, n), pick_value());
			endcase
		end else if (n > 0 && $urandom_range(99) < 80) begin
			f = $urandom_range(1, n);
			l = $urandom_range(f, n);
			send_query(f, l);
		end else begin
			send_query($urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX));
		end
	endtask

	task automatic test_directed_cases();
		send_query(1, 1);
		send_query(0, POS_MAX);
		send_insert(0, VALUE_MAX);
		send_insert(POS_MAX, VALUE_MIN);
		send_insert(CAPACITY, 0);
		send_insert(0, -1);
		send_insert(1, EMPTY_SENTINEL);
		// Two entries above the sentinel, so a query over them must not report it.
		send_insert(5, EMPTY_SENTINEL + 1);
		send_insert(6, VALUE_MAX - 1);
		send_query(1, 7);
		send_query(0, POS_MAX);
		send_query(3, 3);
		send_query(6, 7);
		send_query(5, 2);
		send_query(8, 20);
		send_query(POS_MAX, POS_MAX);
		send_query(7, 7);
		send_query(1, 1);
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) send_random_item(80);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_cycles = 400;
		repeat (24) send_random_item(70);
		release_request();
		while (awaited_responses.size() != 0) @(posedge clk);
		repeat (8) send_random_item(70);
	endtask

	task automatic test_full_store();
		send_idle_pct = 10;
		recv_idle_pct = 10;
		while (seq_cells.size() < CAPACITY)
			send_random_item(97);
		// Every insert from here on is dropped and must leave the store unchanged.
		send_insert(0, VALUE_MIN);
		send_query(0, POS_MAX);
		send_insert(POS_MAX, VALUE_MIN);
		send_query(CAPACITY, CAPACITY);
		send_query(1, 1);
		send_query(CAPACITY + 1, POS_MAX);
		send_insert(CAPACITY / 2, pick_value());
		send_query(CAPACITY / 2, CAPACITY);
	endtask

	initial begin : response_sink
		response_t exp_rsp;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (awaited_responses.size() == 0) begin
					$error("response beat with nothing expected: minimum %0d, status %0d",
						rsp_ch.minimum, rsp_ch.status);
					error_count++;
				end else begin
					exp_rsp = awaited_responses.pop_front();
					if (rsp_ch.minimum !== exp_rsp.minimum) begin
						$error("minimum mismatch: expected %0d, actual %0d",
							exp_rsp.minimum, rsp_ch.minimum);
						error_count++;
					end
					if (rsp_ch.status !== exp_rsp.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							exp_rsp.status, rsp_ch.status);
						error_count++;
					end
				end
			end
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.command     <= CMD_INSERT;
		req_ch.position    <= '0;
		req_ch.value       <= '0;
		req_ch.range_first <= '0;
		req_ch.range_last  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_traffic(20, 83, 100);
		test_random_traffic(83, 20, 100);
		test_random_traffic(0, 0, 100);
		test_backpressure();
		test_full_store();

		release_request();
		while (awaited_responses.size() != 0) @(posedge clk);
		repeat (CAPACITY + 16) @(posedge clk);
		if (error_count == 0 && awaited_responses.size() == 0) begin
			$display("positional_insert_range_min_test passed");
		end else begin
			$display("positional_insert_range_min_test failed");
		end
		$finish;
	end

endmodule
